// ===== src/ipc_pkg.sv =====
package ipc_pkg;

  localparam int N_W       = 10;
  localparam int COUNT_W   = 50;
  localparam int MAX_N_DEF = 255;
  // MAX_N may reach 255, so a nonnegative n compares on its low 9 bits
  localparam int MAG_W     = N_W - 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_RUN,
    S_DRAIN,
    S_EMIT
  } state_t;

endpackage

// ===== src/ipc_if.sv =====
interface ipc_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [ipc_pkg::N_W-1:0]    n_value;

  modport source (output valid, output n_value, input ready);
  modport sink (input valid, input n_value, output ready);
endinterface

interface ipc_out_if;
  logic                              valid;
  logic                              ready;
  logic [ipc_pkg::COUNT_W-1:0]       way_count;
  logic                              out_of_range;

  modport source (output valid, output way_count, output out_of_range, input ready);
  modport sink (input valid, input way_count, input out_of_range, output ready);
endinterface

// ===== src/integer_partition_count_unit.sv =====
// Sequence: the row clear writes entries 0..n, the run makes n*(n+1)/2 store updates, then
// the drain and emit states present the word. Negative, zero or out-of-range n go straight to emit.
// Throughput: one item at a time; the single adder and the store's write port do one
// update per cycle.
// Reset (rst_n, synchronous, active low) clears the sequencer and the output valid; the
// row store is not cleared, each positive in-range item writes entries 0..n before reading them.
module integer_partition_count_unit #(
  parameter int MAX_N = ipc_pkg::MAX_N_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  ipc_in_if.sink          in_ch,
  ipc_out_if.source       out_ch
);

  localparam int AW    = $clog2(MAX_N + 1);
  localparam int DEPTH = MAX_N + 1;
  localparam int CW    = ipc_pkg::COUNT_W;

  ipc_pkg::state_t state_r, state_nxt;

  logic [AW-1:0]  n_r, n_nxt;
  logic [AW-1:0]  pre_r, pre_nxt;
  logic [AW-1:0]  rest_r, rest_nxt;
  logic           wr_pend_r, wr_pend_nxt;
  logic [AW-1:0]  wr_addr_r, wr_addr_nxt;
  logic           last_r, last_nxt;
  logic [CW-1:0]  res_count_r, res_count_nxt;
  logic           res_flag_r, res_flag_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [CW-1:0]  out_count_r;
  logic           out_flag_r;

  logic [CW-1:0]  mem [DEPTH];
  logic [CW-1:0]  rd_a_r, rd_b_r;
  logic           byp_a_r, byp_b_r;
  logic [CW-1:0]  byp_data_r;

  logic           we;
  logic [AW-1:0]  waddr;
  logic [CW-1:0]  wdata;
  logic [AW-1:0]  raddr_a, raddr_b;
  logic [CW-1:0]  opa, opb, sum;

  logic           in_fire;
  logic           n_neg, n_over, n_zero;
  logic           emit_go;

  assign in_ch.ready      = (state_r == ipc_pkg::S_IDLE);
  assign in_fire          = in_ch.valid && in_ch.ready;
  assign n_neg            = in_ch.n_value[ipc_pkg::N_W-1];
  assign n_over           = !n_neg &&
                            (in_ch.n_value[ipc_pkg::MAG_W-1:0] > ipc_pkg::MAG_W'(MAX_N));
  assign n_zero           = (in_ch.n_value == '0);
  assign emit_go          = !out_valid_r || out_ch.ready;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.way_count    = out_count_r;
  assign out_ch.out_of_range = out_flag_r;

  // shared adder, with bypass of a write to the same address in the read cycle
  assign opa = byp_a_r ? byp_data_r : rd_a_r;
  assign opb = byp_b_r ? byp_data_r : rd_b_r;
  assign sum = opa + opb;

  assign raddr_a = rest_r;
  assign raddr_b = rest_r - pre_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ipc_pkg::S_IDLE: begin
        if (in_fire) begin
          if (n_neg || n_over || n_zero) begin
            state_nxt = ipc_pkg::S_EMIT;
          end else begin
            state_nxt = ipc_pkg::S_CLEAR;
          end
        end
      end
      ipc_pkg::S_CLEAR: begin
        if (rest_r == n_r) state_nxt = ipc_pkg::S_RUN;
      end
      ipc_pkg::S_RUN: begin
        if (rest_r == n_r && pre_r == AW'(1)) state_nxt = ipc_pkg::S_DRAIN;
      end
      ipc_pkg::S_DRAIN: begin
        state_nxt = ipc_pkg::S_EMIT;
      end
      ipc_pkg::S_EMIT: begin
        if (emit_go) state_nxt = ipc_pkg::S_IDLE;
      end
      default: state_nxt = ipc_pkg::S_IDLE;
    endcase
  end

  // sequencer outputs and datapath
  always_comb begin
    n_nxt         = n_r;
    pre_nxt       = pre_r;
    rest_nxt      = rest_r;
    wr_pend_nxt   = 1'b0;
    wr_addr_nxt   = rest_r;
    last_nxt      = (pre_r == AW'(1)) && (rest_r == n_r);
    res_count_nxt = res_count_r;
    res_flag_nxt  = res_flag_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    we            = 1'b0;
    waddr         = wr_addr_r;
    wdata         = sum;

    case (state_r)
      ipc_pkg::S_IDLE: begin
        if (in_fire) begin
          n_nxt         = in_ch.n_value[AW-1:0];
          rest_nxt      = '0;
          res_flag_nxt  = n_over;
          res_count_nxt = (n_zero) ? CW'(1) : '0;
        end
      end
      ipc_pkg::S_CLEAR: begin
        we    = 1'b1;
        waddr = rest_r;
        wdata = (rest_r == '0) ? CW'(1) : '0;
        if (rest_r == n_r) begin
          pre_nxt  = n_r;
          rest_nxt = n_r;
        end else begin
          rest_nxt = rest_r + AW'(1);
        end
      end
      ipc_pkg::S_RUN: begin
        wr_pend_nxt = 1'b1;
        // advance along the row, then drop to the next lower part size
        if (rest_r == n_r) begin
          pre_nxt  = pre_r - AW'(1);
          rest_nxt = pre_r - AW'(1);
        end else begin
          rest_nxt = rest_r + AW'(1);
        end
      end
      ipc_pkg::S_EMIT: begin
        if (emit_go) out_valid_nxt = 1'b1;
      end
      default: ;
    endcase

    if (wr_pend_r) begin
      we = 1'b1;
      if (last_r) res_count_nxt = sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ipc_pkg::S_IDLE;
      wr_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wr_pend_r   <= wr_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r         <= n_nxt;
    pre_r       <= pre_nxt;
    rest_r      <= rest_nxt;
    wr_addr_r   <= wr_addr_nxt;
    last_r      <= last_nxt;
    res_count_r <= res_count_nxt;
    res_flag_r  <= res_flag_nxt;
    byp_a_r     <= we && (waddr == raddr_a);
    byp_b_r     <= we && (waddr == raddr_b);
    byp_data_r  <= wdata;
    if (state_r == ipc_pkg::S_EMIT && emit_go) begin
      out_count_r <= res_count_r;
      out_flag_r  <= res_flag_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_a_r <= mem[raddr_a];
    rd_b_r <= mem[raddr_b];
  end

`ifndef SYNTHESIS
  a_flag_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_flag_r |-> out_count_r == '0)
    else $error("out_of_range word carries a nonzero count");

  a_run_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ipc_pkg::S_RUN |-> pre_r != '0 && rest_r >= pre_r && rest_r <= n_r)
    else $error("update indexes outside the active row");

  a_write_follows_run: assert property (@(posedge clk) disable iff (!rst_n)
    wr_pend_r |-> $past(state_r) == ipc_pkg::S_RUN)
    else $error("store update without a read issued the cycle before");

  a_compute_starts_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !n_neg && !n_over && !n_zero |=> state_r == ipc_pkg::S_CLEAR)
    else $error("positive in-range item did not start the row clear");
`endif

endmodule
